/* rtl/lsa_pkg.sv */
// lsa_pkg: shared constants, field widths and command/status codes of the
// light slot allocator. No dependencies; compiled first.

package lsa_pkg;

   // table size and derived widths
   localparam int SLOTS   = 1024;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int COUNT_W = $clog2(SLOTS + 1);

   // item field widths
   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 10;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 11;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_FREE  = 2'd3
   } status_type;

   // per-slot flag word kept in the flag memory
   typedef struct packed {
      logic enabled;
      logic on_free;
   } flags_type;

endpackage

/* rtl/lsa_req_if.sv */
// lsa_req_if: request channel (command, slot index, enable) with
// valid/ready handshake. Depends on lsa_pkg.

interface lsa_req_if import lsa_pkg::*;;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [INDEX_W-1:0] slot_index;
   logic               enable_in;

   modport source (output valid, output command, output slot_index, output enable_in,
                   input ready);
   modport sink   (input valid, input command, input slot_index, input enable_in,
                   output ready);

endinterface

/* rtl/lsa_rsp_if.sv */
// lsa_rsp_if: response channel (slot, status, fill level) with
// valid/ready handshake. Depends on lsa_pkg.

interface lsa_rsp_if import lsa_pkg::*;;

   logic                valid;
   logic                ready;
   logic [INDEX_W-1:0]  slot_out;
   logic [STATUS_W-1:0] status;
   logic [FILL_W-1:0]   fill_level;

   modport source (output valid, output slot_out, output status, output fill_level,
                   input ready);
   modport sink   (input valid, input slot_out, input status, input fill_level,
                   output ready);

endinterface

/* rtl/lsa_ram.sv */
// lsa_ram: generic simple dual-port RAM, one write and one read port,
// read data registered. No dependencies.

module lsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/light_slot_allocator_top.sv */
// light_slot_allocator_top: slot allocator with a LIFO free stack and
// per-slot flags held in two lsa_ram instances.
// Depends on lsa_pkg, lsa_req_if, lsa_rsp_if and lsa_ram.
//
//   channel   dir   handshake      payload
//   req_port  in    valid/ready    command, slot_index, enable_in
//   rsp_port  out   valid/ready    slot_out, status, fill_level
//
// Each item is accepted, which issues the reads of the free stack top and of
// the slot's flags, and then its execute cycle uses the read data and
// writes both memories back. The result sits in an output register, so the
// next item is taken while it waits; a second result stalls in the execute
// cycle until the first is taken. Reset (synchronous) empties stack and
// table at once; memory contents need no clearing pass.

module light_slot_allocator_top import lsa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lsa_req_if.sink   req_port,
   lsa_rsp_if.source rsp_port
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;

   // captured item
   cmd_type            cmd_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic               en_ff;

   // table state
   logic [COUNT_W-1:0] depth_ff, depth_in;
   logic [COUNT_W-1:0] used_ff, used_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_slot_ff, rsp_slot_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [FILL_W-1:0]   rsp_fill_ff;

   // memory ports
   logic              stack_we, flag_we;
   logic [SLOT_W-1:0] stack_wr_addr, stack_rd_addr, flag_wr_addr, flag_rd_addr;
   logic [SLOT_W-1:0] stack_wr_data, stack_rd_data;
   flags_type         flag_wr_data, flag_rd_data;

   logic accept, fire, out_free, in_range;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign accept         = req_port.valid && req_port.ready;
   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign fire           = (state_ff == ST_EXEC) && out_free;

   // reads issued in the accept cycle
   assign stack_rd_addr = SLOT_W'(depth_ff - COUNT_W'(1));
   assign flag_rd_addr  = SLOT_W'(req_port.slot_index);

   lsa_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_wr_addr),
      .wr_data (stack_wr_data),
      .rd_en   (accept),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd_data)
   );

   lsa_ram #(.WIDTH($bits(flags_type)), .DEPTH(SLOTS)) u_flag_ram (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_wr_addr),
      .wr_data (flag_wr_data),
      .rd_en   (accept),
      .rd_addr (flag_rd_addr),
      .rd_data (flag_rd_data)
   );

   assign in_range = (COUNT_W'(idx_ff) < used_ff) && (COUNT_W'(idx_ff) < COUNT_W'(SLOTS));

   // execute: decide, write back, form the result
   always_comb begin
      depth_in      = depth_ff;
      used_in       = used_ff;
      rsp_slot_in   = idx_ff;
      rsp_status_in = STAT_OK;
      stack_we      = 1'b0;
      stack_wr_addr = SLOT_W'(depth_ff);
      stack_wr_data = SLOT_W'(idx_ff);
      flag_we       = 1'b0;
      flag_wr_addr  = SLOT_W'(idx_ff);
      flag_wr_data  = '{enabled: 1'b1, on_free: 1'b0};
      unique case (cmd_ff)
         CMD_CLEAR: begin
            depth_in = '0;
            used_in  = '0;
         end
         CMD_ADD: begin
            priority if (depth_ff != '0) begin
               // reuse the most recently freed slot
               depth_in     = depth_ff - COUNT_W'(1);
               rsp_slot_in  = INDEX_W'(stack_rd_data);
               flag_we      = fire;
               flag_wr_addr = stack_rd_data;
            end else if (used_ff < COUNT_W'(SLOTS)) begin
               // hand out the next unused slot
               used_in      = used_ff + COUNT_W'(1);
               rsp_slot_in  = INDEX_W'(used_ff);
               flag_we      = fire;
               flag_wr_addr = SLOT_W'(used_ff);
            end else begin
               rsp_slot_in   = '0;
               rsp_status_in = STAT_FULL;
            end
         end
         CMD_UPDATE: begin
            if (in_range) begin
               flag_we      = fire;
               flag_wr_data = '{enabled: en_ff, on_free: flag_rd_data.on_free};
            end else begin
               rsp_status_in = STAT_RANGE;
            end
         end
         CMD_REMOVE: begin
            priority if (!in_range) begin
               rsp_status_in = STAT_RANGE;
            end else if (flag_rd_data.on_free) begin
               rsp_status_in = STAT_FREE;
            end else if (depth_ff < COUNT_W'(SLOTS)) begin
               // disable and push onto the free stack
               depth_in     = depth_ff + COUNT_W'(1);
               stack_we     = fire;
               flag_we      = fire;
               flag_wr_data = '{enabled: 1'b0, on_free: 1'b1};
            end else begin
               rsp_status_in = STAT_OK;
            end
         end
         default: begin
            rsp_status_in = STAT_OK;
         end
      endcase
   end

   // sequencing
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: begin
            if (fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         depth_ff     <= '0;
         used_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            depth_ff      <= depth_in;
            used_ff       <= used_in;
            rsp_slot_ff   <= rsp_slot_in;
            rsp_status_ff <= rsp_status_in;
            rsp_fill_ff   <= FILL_W'(used_in);
         end
      end
   end

   // captured item
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_type'(req_port.command);
         idx_ff <= req_port.slot_index;
         en_ff  <= req_port.enable_in;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.slot_out   = rsp_slot_ff;
   assign rsp_port.status     = rsp_status_ff;
   assign rsp_port.fill_level = rsp_fill_ff;

`ifndef SYNTHESIS
   // fill level never exceeds the table size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= COUNT_W'(SLOTS))
      else $error("fill level above table size");

   // freed slots are a subset of handed-out slots
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= used_ff)
      else $error("free stack deeper than fill level");

   // table full is reported only with an empty stack and a full table
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      fire && rsp_status_in == STAT_FULL |-> depth_ff == '0 && used_ff == COUNT_W'(SLOTS))
      else $error("full reported while a slot is available");

   // an item leaves the execute cycle with a result loaded
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("result not loaded after execute");
`endif

endmodule
